// ===== src/cbm_pkg.sv =====
`default_nettype none
package cbm_pkg;

	// input item, one bus access or tick
	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] address;
		logic [7:0]  write_data;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [2:0]  target;
		logic [18:0] phys_addr;
		logic        ram_write;
		logic        irq_out;
		logic [1:0]  mirror_mode;
	} out_item_t;

	localparam logic [1:0] OP_CPU_READ  = 2'd0;
	localparam logic [1:0] OP_CPU_WRITE = 2'd1;
	localparam logic [1:0] OP_PPU_READ  = 2'd2;
	localparam logic [1:0] OP_TICK      = 2'd3;

	localparam logic [2:0] TGT_NONE    = 3'd0;
	localparam logic [2:0] TGT_PRG_ROM = 3'd1;
	localparam logic [2:0] TGT_PRG_RAM = 3'd2;
	localparam logic [2:0] TGT_CHR_ROM = 3'd3;
	localparam logic [2:0] TGT_ZERO    = 3'd4;

	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_ROM_MASK = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_RAM_MASK = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_MASK = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_PRESENT  = 8'd3;

	localparam logic [3:0] CMD_LOW_WINDOW = 4'd8;
	localparam logic [3:0] CMD_PRG_0      = 4'd9;
	localparam logic [3:0] CMD_PRG_1      = 4'd10;
	localparam logic [3:0] CMD_PRG_2      = 4'd11;
	localparam logic [3:0] CMD_MIRROR     = 4'd12;
	localparam logic [3:0] CMD_IRQ_CTRL   = 4'd13;
	localparam logic [3:0] CMD_IRQ_LO     = 4'd14;
	localparam logic [3:0] CMD_IRQ_HI     = 4'd15;

	// address page, address[15:13]
	localparam logic [2:0] PAGE_6000 = 3'd3;
	localparam logic [2:0] PAGE_8000 = 3'd4;
	localparam logic [2:0] PAGE_A000 = 3'd5;

	typedef struct packed {
		logic [5:0] prg_rom_mask;
		logic [4:0] prg_ram_mask;
		logic [7:0] chr_rom_mask;
		logic       chr_present;
	} cbm_cfg_t;

	typedef struct packed {
		logic [3:0]       command_index;
		logic [7:0][7:0]  chr_bank;
		logic [2:0][5:0]  prg_bank;
		logic [5:0]       low_window_bank;
		logic             ram_enabled;
		logic             ram_selected;
		logic [1:0]       mirroring;
		logic             irq_allowed;
		logic             count_enabled;
		logic [15:0]      irq_count;
		logic             irq_pending;
	} cbm_state_t;

endpackage
`default_nettype wire

// ===== src/cbm_regs.sv =====
`default_nettype none
module cbm_regs (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [cbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [7:0]                    cfg_data,
	input  wire                          step,
	input  wire cbm_pkg::in_item_t       item,
	output cbm_pkg::cbm_cfg_t            cfg,
	output cbm_pkg::cbm_state_t          cur,
	output cbm_pkg::cbm_state_t          nxt
);
	import cbm_pkg::*;

	cbm_cfg_t   cfg_q;
	cbm_state_t st_q;
	cbm_state_t st_d;
	logic [2:0] page;
	logic       is_wr;

	assign page  = item.address[15:13];
	assign is_wr = (item.operation == OP_CPU_WRITE);

	always_comb begin
		st_d = st_q;
		if (is_wr && page == PAGE_8000) begin
			st_d.command_index = item.write_data[3:0];
		end else if (is_wr && page == PAGE_A000) begin
			case (st_q.command_index)
				CMD_LOW_WINDOW: begin
					st_d.ram_enabled     = item.write_data[7];
					st_d.ram_selected    = item.write_data[6];
					st_d.low_window_bank = item.write_data[5:0];
				end
				CMD_PRG_0: st_d.prg_bank[0] = item.write_data[5:0];
				CMD_PRG_1: st_d.prg_bank[1] = item.write_data[5:0];
				CMD_PRG_2: st_d.prg_bank[2] = item.write_data[5:0];
				CMD_MIRROR: st_d.mirroring = item.write_data[1:0];
				CMD_IRQ_CTRL: begin
					st_d.irq_allowed   = item.write_data[0];
					st_d.count_enabled = item.write_data[7];
					st_d.irq_pending   = 1'b0;
				end
				CMD_IRQ_LO: st_d.irq_count[7:0]  = item.write_data;
				CMD_IRQ_HI: st_d.irq_count[15:8] = item.write_data;
				default: st_d.chr_bank[st_q.command_index[2:0]] = item.write_data;
			endcase
		end else if (item.operation == OP_TICK && st_q.count_enabled) begin
			st_d.irq_count = st_q.irq_count - 16'd1;
			// wrap from zero to all ones
			if (st_q.irq_count == 16'd0 && st_q.irq_allowed) begin
				st_d.irq_pending = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prg_rom_mask <= 6'h3F;
			cfg_q.prg_ram_mask <= 5'h00;
			cfg_q.chr_rom_mask <= 8'hFF;
			cfg_q.chr_present  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRG_ROM_MASK: cfg_q.prg_rom_mask <= cfg_data[5:0];
				CFG_PRG_RAM_MASK: cfg_q.prg_ram_mask <= cfg_data[4:0];
				CFG_CHR_ROM_MASK: cfg_q.chr_rom_mask <= cfg_data;
				CFG_CHR_PRESENT:  cfg_q.chr_present  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
	assign cur = st_q;
	assign nxt = st_d;
endmodule
`default_nettype wire

// ===== src/cbm_map.sv =====
`default_nettype none
module cbm_map (
	input  wire cbm_pkg::in_item_t   item,
	input  wire cbm_pkg::cbm_cfg_t   cfg,
	input  wire cbm_pkg::cbm_state_t cur,
	input  wire cbm_pkg::cbm_state_t nxt,
	output cbm_pkg::out_item_t       result
);
	import cbm_pkg::*;

	logic [2:0]  page;
	logic [5:0]  rom_bank;
	logic [18:0] rom_phys;
	logic [18:0] ram_phys;
	logic [18:0] chr_phys;
	logic [7:0]  chr_sel;

	assign page     = item.address[15:13];
	assign rom_phys = {rom_bank & cfg.prg_rom_mask, item.address[12:0]};
	assign ram_phys = {1'b0, cur.low_window_bank[4:0] & cfg.prg_ram_mask, item.address[12:0]};
	assign chr_sel  = cur.chr_bank[item.address[12:10]] & cfg.chr_rom_mask;
	assign chr_phys = {1'b0, chr_sel, item.address[9:0]};

	always_comb begin
		case (item.address[14:13])
			2'd0:    rom_bank = cur.prg_bank[0];
			2'd1:    rom_bank = cur.prg_bank[1];
			2'd2:    rom_bank = cur.prg_bank[2];
			default: rom_bank = 6'h3F; // $E000 page, last bank after masking
		endcase
		if (page == PAGE_6000) begin
			rom_bank = cur.low_window_bank;
		end
	end

	always_comb begin
		result.target      = TGT_NONE;
		result.phys_addr   = '0;
		result.ram_write   = 1'b0;
		result.irq_out     = nxt.irq_pending;
		result.mirror_mode = nxt.mirroring;
		case (item.operation)
			OP_CPU_READ: begin
				if (item.address[15]) begin
					result.target    = TGT_PRG_ROM;
					result.phys_addr = rom_phys;
				end else if (page == PAGE_6000) begin
					if (!cur.ram_selected) begin
						result.target    = TGT_PRG_ROM;
						result.phys_addr = rom_phys;
					end else if (cur.ram_enabled) begin
						result.target    = TGT_PRG_RAM;
						result.phys_addr = ram_phys;
					end else begin
						result.target = TGT_ZERO;
					end
				end
			end
			OP_CPU_WRITE: begin
				if (page == PAGE_6000 && cur.ram_enabled && cur.ram_selected) begin
					result.target    = TGT_PRG_RAM;
					result.phys_addr = ram_phys;
					result.ram_write = 1'b1;
				end
			end
			OP_PPU_READ: begin
				if (cfg.chr_present) begin
					result.target    = TGT_CHR_ROM;
					result.phys_addr = chr_phys;
				end else begin
					result.target = TGT_ZERO;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/cartridge_bank_mapper_irq_core.sv =====
`default_nettype none
// channel | signals                        | accepted when
// --------+--------------------------------+----------------------------
// in      | in_valid, in_ready, in_item    | in_valid && in_ready
// out     | out_valid, out_ready, out_item | out_valid && out_ready
// cfg     | cfg_we, cfg_index, cfg_data    | cfg_we (no wait, write only)
//
// One item per clock sustained while out_ready is high; each item passes from
// acceptance to result through the input register, where the mapper state is read
// and updated, and the result register. Reset clears the mapper state, the valid
// flags, and loads the default bank masks. A stalled result register holds the input
// item in place; in_ready stays high while the result is taken in the same cycle.
module cartridge_bank_mapper_irq_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire cbm_pkg::in_item_t       in_item,
	output logic                         out_valid,
	input  wire                          out_ready,
	output cbm_pkg::out_item_t           out_item,
	input  wire                          cfg_we,
	input  wire [cbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [7:0]                    cfg_data
);
	import cbm_pkg::*;

	// input register
	logic       valid_s1;
	in_item_t   item_s1;
	// result register
	logic       out_valid_q;
	out_item_t  out_item_q;

	logic       advance;
	cbm_cfg_t   cfg;
	cbm_state_t cur;
	cbm_state_t nxt;
	out_item_t  result;

	// the item in s1 moves on once the result register is free or being emptied;
	// that same edge commits its state update
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	// mapper registers, IRQ counter and cartridge configuration
	cbm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.cur       (cur),
		.nxt       (nxt)
	);

	// address translation; IRQ line and mirroring reflect the state after the item
	cbm_map u_map (
		.item   (item_s1),
		.cfg    (cfg),
		.cur    (cur),
		.nxt    (nxt),
		.result (result)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
endmodule
`default_nettype wire
